@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL files of the LED ring pattern generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define LRPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that an antecedent implies a consequent in the same cycle.
`define LRPG_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define LRPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lrpg_pkg.sv @@
// Package with the types, constants, microcode and color helpers of the LED ring generator.
`timescale 1ns / 1ps

package lrpg_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED      = 1'd1;

    // Display modes with behavior of their own.
    localparam logic [2:0] MODE_RAINBOW = 3'd0;
    localparam logic [2:0] MODE_FADE    = 3'd1;

    // Register reset values.
    localparam logic [7:0]  BRIGHTNESS_RST = 8'd64;
    localparam logic [15:0] SPEED_RST      = 16'd40;

    // Datapath operations selected by the microcode.
    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_ADVANCE,
        OP_DIM,
        OP_EMIT,
        OP_HUE_SEL,
        OP_MUL_R,
        OP_MUL_G,
        OP_MUL_B,
        OP_DIV_B,
        OP_NEXT_LED,
        OP_NOP,
        OP_FADE_MUL,
        OP_FADE_SCALE
    } op_t;

    // Jump conditions; a jump goes to the target, otherwise the step counter advances.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_IN,
        C_MODE1,
        C_OUT_BUSY,
        C_MORE
    } cond_t;

    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    // Program addresses.
    localparam pc_t S_IDLE       = 4'd0;
    localparam pc_t S_ADVANCE    = 4'd1;
    localparam pc_t S_DIM        = 4'd2;
    localparam pc_t S_EMIT_CTR   = 4'd3;
    localparam pc_t S_HUE_SEL    = 4'd4;
    localparam pc_t S_LOOP       = 4'd5;
    localparam pc_t S_MUL_G      = 4'd6;
    localparam pc_t S_MUL_B      = 4'd7;
    localparam pc_t S_DIV_B      = 4'd8;
    localparam pc_t S_EMIT       = 4'd9;
    localparam pc_t S_NEXT_LED   = 4'd10;
    localparam pc_t S_DONE       = 4'd11;
    localparam pc_t S_FADE_MUL   = 4'd12;
    localparam pc_t S_FADE_SCALE = 4'd13;
    localparam pc_t S_LAST       = S_FADE_SCALE;

    // One control word of the program.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } ucode_t;

    // Status that the datapath hands to the sequencer for its jumps.
    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic fade_mode;
        logic more_leds;
    } seq_status_t;

    // Three color channels, red in entry 0.
    typedef logic [2:0][7:0] rgb_t;

    // The program: centre LED first, then a shared per-LED loop of multiply steps.
    function automatic ucode_t ucode(input pc_t addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: S_IDLE};
        case (addr)
            S_IDLE:       w = '{op: OP_ACCEPT,     cond: C_NO_IN,    target: S_IDLE};
            S_ADVANCE:    w = '{op: OP_ADVANCE,    cond: C_MODE1,    target: S_FADE_MUL};
            S_DIM:        w = '{op: OP_DIM,        cond: C_NEXT,     target: S_IDLE};
            S_EMIT_CTR:   w = '{op: OP_EMIT,       cond: C_OUT_BUSY, target: S_EMIT_CTR};
            S_HUE_SEL:    w = '{op: OP_HUE_SEL,    cond: C_NEXT,     target: S_IDLE};
            S_LOOP:       w = '{op: OP_MUL_R,      cond: C_NEXT,     target: S_IDLE};
            S_MUL_G:      w = '{op: OP_MUL_G,      cond: C_NEXT,     target: S_IDLE};
            S_MUL_B:      w = '{op: OP_MUL_B,      cond: C_NEXT,     target: S_IDLE};
            S_DIV_B:      w = '{op: OP_DIV_B,      cond: C_NEXT,     target: S_IDLE};
            S_EMIT:       w = '{op: OP_EMIT,       cond: C_OUT_BUSY, target: S_EMIT};
            S_NEXT_LED:   w = '{op: OP_NEXT_LED,   cond: C_MORE,     target: S_LOOP};
            S_DONE:       w = '{op: OP_NOP,        cond: C_ALWAYS,   target: S_IDLE};
            S_FADE_MUL:   w = '{op: OP_FADE_MUL,   cond: C_NEXT,     target: S_IDLE};
            S_FADE_SCALE: w = '{op: OP_FADE_SCALE, cond: C_ALWAYS,   target: S_LOOP};
            default:      w = '{op: OP_NOP,        cond: C_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

    // Hue of the fixed-color modes; rainbow and fade do not use it.
    function automatic logic [7:0] fixed_hue(input logic [2:0] mode);
        logic [7:0] h;
        case (mode)
            3'd2:    h = 8'd20;
            3'd3:    h = 8'd40;
            3'd4:    h = 8'd85;
            3'd5:    h = 8'd135;
            3'd6:    h = 8'd190;
            3'd7:    h = 8'd205;
            default: h = 8'd0;
        endcase
        return h;
    endfunction

    // Unscaled color of a hue on the three-segment wheel.
    function automatic rgb_t hue_wheel(input logic [7:0] hue);
        logic [7:0] h;
        logic [7:0] k;
        logic [9:0] k3;
        rgb_t       c;
        h = ~hue;
        if (h < 8'd85)
        begin
            k = h;
        end
        else if (h < 8'd170)
        begin
            k = h - 8'd85;
        end
        else
        begin
            k = h - 8'd170;
        end
        k3 = {2'b00, k} + {1'b0, k, 1'b0};
        if (h < 8'd85)
        begin
            c[0] = 8'd255 - k3[7:0];
            c[1] = 8'd0;
            c[2] = k3[7:0];
        end
        else if (h < 8'd170)
        begin
            c[0] = 8'd0;
            c[1] = k3[7:0];
            c[2] = 8'd255 - k3[7:0];
        end
        else
        begin
            c[0] = k3[7:0];
            c[1] = 8'd255 - k3[7:0];
            c[2] = 8'd0;
        end
        return c;
    endfunction

    // Floor of x / 255, exact for any 16-bit x up to 65279, where the quotient fits in eight bits.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

@@ rtl/lrpg_seq.sv @@
// Microcode sequencer: step counter, program table and conditional jumps.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lrpg_seq
(
    input  logic                clk,
    input  logic                rst_n,
    input  lrpg_pkg::seq_status_t status,
    output lrpg_pkg::op_t       op
);
    import lrpg_pkg::*;

    pc_t    pc_reg;
    pc_t    pc_next;
    ucode_t word;
    logic   jump;

    // Fetch the control word of the current step.
    assign word = ucode(pc_reg);
    assign op   = word.op;

    // Evaluate the jump condition.
    always_comb
    begin
        case (word.cond)
            C_NEXT:     jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !status.in_valid;
            C_MODE1:    jump = status.fade_mode;
            C_OUT_BUSY: jump = status.out_busy;
            C_MORE:     jump = status.more_leds;
            default:    jump = 1'b0;
        endcase
        pc_next = jump ? word.target : pc_reg + pc_t'(1);
    end

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // The step counter stays inside the program.
    `LRPG_ASSERT(a_pc_in_program, pc_reg <= S_LAST, "step counter left the program")

endmodule

@@ rtl/led_ring_pattern_generator_unit.sv @@
// Top level of the LED ring pattern generator: registers, color datapath and output stage.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, button_pressed             | input item
//  out     | out_valid, out_ready, led_index, red, green,   | result item
//          | blue, last_led                                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | register write
//
// One input item yields LED_COUNT result items, centre LED first.
// The microcode loop uses one shared 8x8 multiplier for each color channel in turn.
// Reset clears the sequencer, mode, button, phase, LED counter and output valid
// registers and restores the register values; the color datapath and output payload
// registers are not reset. A stalled output holds the sequencer at its emit step;
// cfg_ready is always high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_ring_pattern_generator_unit
#(
    parameter int LED_COUNT = 7
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             button_pressed,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       led_index,
    output logic [7:0]                       red,
    output logic [7:0]                       green,
    output logic [7:0]                       blue,
    output logic                             last_led,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lrpg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [15:0]                      cfg_data
);
    import lrpg_pkg::*;

    localparam int              LED_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [LED_W-1:0] LAST_IDX = LED_W'(LED_COUNT - 1);
    localparam logic [7:0]      HUE_STEP = 8'(255 / (LED_COUNT - 1));

    op_t         op;
    seq_status_t status;

    logic [7:0]       bri_reg;
    logic [15:0]      speed_reg;
    logic [2:0]       mode_reg;
    logic             btn_reg;
    logic [15:0]      rphase_reg;
    logic [7:0]       fphase_reg;
    logic [LED_W-1:0] led_reg;
    logic [7:0]       hue_reg;
    logic [7:0]       scale_reg;
    logic [15:0]      prod_reg;
    logic [7:0]       r_reg;
    logic [7:0]       g_reg;
    logic [7:0]       b_reg;

    logic             out_valid_reg;
    logic [2:0]       led_index_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic             last_led_reg;

    logic       in_take;
    logic       out_free;
    logic       emit;
    logic       halve;
    rgb_t       base;
    logic [7:0] fade_f;
    logic [7:0] mul_a;
    logic [7:0] mul_b;
    logic [7:0] quot;

    // Sequencer.
    lrpg_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .op     (op)
    );

    // Handshakes and jump status.
    assign in_ready  = (op == OP_ACCEPT);
    assign in_take   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = (op == OP_EMIT) && out_free;

    assign status.in_valid  = in_valid;
    assign status.out_busy  = !out_free;
    assign status.fade_mode = (mode_reg == MODE_FADE);
    assign status.more_leds = (led_reg != LAST_IDX);

    // Color and multiplier operand selection.
    assign base   = hue_wheel(hue_reg);
    assign fade_f = fphase_reg[7] ? ~fphase_reg : fphase_reg;
    assign quot   = div255(prod_reg);
    assign halve  = (mode_reg == MODE_FADE) && (led_reg == '0);

    always_comb
    begin
        mul_b = scale_reg;
        case (op)
            OP_MUL_R:    mul_a = base[0];
            OP_MUL_G:    mul_a = base[1];
            OP_MUL_B:    mul_a = base[2];
            OP_FADE_MUL:
            begin
                mul_a = fade_f;
                mul_b = bri_reg;
            end
            default:     mul_a = base[0];
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bri_reg   <= BRIGHTNESS_RST;
            speed_reg <= SPEED_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BRIGHTNESS: bri_reg   <= cfg_data[7:0];
                REG_SPEED:      speed_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Mode, button and animation phases.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RAINBOW;
            btn_reg    <= 1'b0;
            rphase_reg <= '0;
            fphase_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                if (button_pressed && !btn_reg)
                begin
                    mode_reg <= mode_reg + 3'd1;
                end
                btn_reg <= button_pressed;
            end
            if (op == OP_ADVANCE)
            begin
                if (mode_reg == MODE_RAINBOW)
                begin
                    rphase_reg <= rphase_reg + speed_reg;
                end
                if (mode_reg == MODE_FADE)
                begin
                    fphase_reg <= fphase_reg + 8'd1;
                end
            end
        end
    end

    // LED counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg <= '0;
        end
        else if (op == OP_ADVANCE)
        begin
            led_reg <= '0;
        end
        else if ((op == OP_HUE_SEL) || (op == OP_NEXT_LED))
        begin
            led_reg <= led_reg + LED_W'(1);
        end
    end

    // Color datapath: hue, scale, product and channel results.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_DIM:
            begin
                r_reg <= {2'b00, bri_reg[7:2]};
                g_reg <= {2'b00, bri_reg[7:2]};
                b_reg <= {2'b00, bri_reg[7:2]};
            end
            OP_HUE_SEL:
            begin
                hue_reg   <= (mode_reg == MODE_RAINBOW) ? rphase_reg[15:8] + HUE_STEP
                                                        : fixed_hue(mode_reg);
                scale_reg <= bri_reg;
            end
            OP_MUL_R:    prod_reg <= {8'd0, mul_a} * {8'd0, mul_b};
            OP_MUL_G:
            begin
                r_reg    <= quot;
                prod_reg <= {8'd0, mul_a} * {8'd0, mul_b};
            end
            OP_MUL_B:
            begin
                g_reg    <= quot;
                prod_reg <= {8'd0, mul_a} * {8'd0, mul_b};
            end
            OP_DIV_B:    b_reg <= quot;
            OP_NEXT_LED:
            begin
                if (mode_reg == MODE_RAINBOW)
                begin
                    hue_reg <= hue_reg + HUE_STEP;
                end
            end
            OP_FADE_MUL: prod_reg <= {8'd0, mul_a} * {8'd0, mul_b};
            OP_FADE_SCALE:
            begin
                scale_reg <= bri_reg - quot;
                hue_reg   <= 8'd0;
            end
            default:     ;
        endcase
    end

    // Output stage: valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output stage: payload, the fade centre LED is halved here.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            led_index_reg <= 3'(led_reg);
            red_reg       <= halve ? {1'b0, r_reg[7:1]} : r_reg;
            green_reg     <= halve ? {1'b0, g_reg[7:1]} : g_reg;
            blue_reg      <= halve ? {1'b0, b_reg[7:1]} : b_reg;
            last_led_reg  <= (led_reg == LAST_IDX);
        end
    end

    assign out_valid = out_valid_reg;
    assign led_index = led_index_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;
    assign last_led  = last_led_reg;

    // An accepted item starts a frame; no second item is taken right after it.
    `LRPG_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready,
        "input taken twice in a row")
    // A frame's final LED carries the last index.
    `LRPG_ASSERT_IMPL(a_last_index, out_valid && last_led, led_index == 3'(LED_COUNT - 1),
        "last_led on a wrong index")
    // No new item is taken while the sequencer still emits LEDs.
    `LRPG_ASSERT_IMPL(a_idle_on_accept, in_ready, op == OP_ACCEPT,
        "input ready outside the idle step")

endmodule
